// File: src/wlh_pkg.sv
// ----------------------------------------------------------------------------
// wlh_pkg
// shared types and constants of the word length histogram
// ----------------------------------------------------------------------------
package wlh_pkg;

    localparam int MAX_LENGTH_DEF = 1023;
    localparam int COUNT_BITS_DEF = 16;

    // widths of the fixed transaction fields
    localparam int ACTION_BITS = 2;
    localparam int BYTE_BITS   = 8;
    localparam int INDEX_BITS  = 10;
    localparam int OUT_COUNT_BITS = 16;
    // widest bin address over the parameter range
    localparam int ADDR_BITS   = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [ACTION_BITS-1:0] ACT_FEED = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_EOT  = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_READ = 2'd2;

    localparam logic [BYTE_BITS-1:0] CHAR_TAB   = 8'h09;
    localparam logic [BYTE_BITS-1:0] CHAR_NL    = 8'h0A;
    localparam logic [BYTE_BITS-1:0] CHAR_SPACE = 8'h20;

    typedef enum logic
    {
        OP_INC,
        OP_READ
    } op_kind_t;

    typedef struct packed
    {
        op_kind_t                kind;
        logic                    in_range;
        logic [INDEX_BITS-1:0]   bin_length;
        logic [ADDR_BITS-1:0]    addr;
    } op_t;

endpackage

// File: src/wlh_ram.sv
// ----------------------------------------------------------------------------
// wlh_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module wlh_ram
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/wlh_front.sv
// ----------------------------------------------------------------------------
// wlh_front
// accepts transactions, tracks the open word and issues bin operations
// ----------------------------------------------------------------------------
module wlh_front
#(
    parameter int MAX_LENGTH = wlh_pkg::MAX_LENGTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [wlh_pkg::ACTION_BITS-1:0] action,
    input  logic [wlh_pkg::BYTE_BITS-1:0]   text_byte,
    input  logic [wlh_pkg::INDEX_BITS-1:0]  bin_index,
    input  logic                            queue_full,
    input  logic                            clear_busy,
    output logic                            push,
    output wlh_pkg::op_t                    op
);

    localparam int LEN_BITS = $clog2(MAX_LENGTH + 1);

    logic                inside_word_reg;
    logic                inside_word_next;
    logic [LEN_BITS-1:0] cur_len_reg;
    logic [LEN_BITS-1:0] cur_len_next;
    logic                accept;
    logic                is_sep;

    assign in_ready = !clear_busy && !queue_full;
    assign accept   = in_valid && in_ready;
    assign is_sep   = (text_byte == wlh_pkg::CHAR_SPACE) || (text_byte == wlh_pkg::CHAR_TAB)
                      || (text_byte == wlh_pkg::CHAR_NL);

    always_comb
    begin
        inside_word_next = inside_word_reg;
        cur_len_next     = cur_len_reg;
        push             = 1'b0;
        op.kind          = wlh_pkg::OP_INC;
        op.in_range      = 1'b1;
        op.bin_length    = bin_index;
        op.addr          = wlh_pkg::ADDR_BITS'(cur_len_reg);
        if (accept)
        begin
            case (action)
                wlh_pkg::ACT_FEED:
                begin
                    if (is_sep)
                    begin
                        push             = inside_word_reg;
                        inside_word_next = 1'b0;
                        cur_len_next     = '0;
                    end
                    else if (inside_word_reg)
                    begin
                        if (cur_len_reg != LEN_BITS'(MAX_LENGTH))
                        begin
                            cur_len_next = cur_len_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        inside_word_next = 1'b1;
                        cur_len_next     = LEN_BITS'(1);
                    end
                end
                wlh_pkg::ACT_EOT:
                begin
                    push             = inside_word_reg;
                    inside_word_next = 1'b0;
                    cur_len_next     = '0;
                end
                wlh_pkg::ACT_READ:
                begin
                    push        = 1'b1;
                    op.kind     = wlh_pkg::OP_READ;
                    op.in_range = (32'(bin_index) <= 32'(MAX_LENGTH));
                    op.addr     = wlh_pkg::ADDR_BITS'(bin_index);
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_word_reg <= 1'b0;
            cur_len_reg     <= '0;
        end
        else
        begin
            inside_word_reg <= inside_word_next;
            cur_len_reg     <= cur_len_next;
        end
    end

endmodule

// File: src/wlh_fifo.sv
// ----------------------------------------------------------------------------
// wlh_fifo
// short operation queue between the front and the back
// ----------------------------------------------------------------------------
module wlh_fifo
#(
    parameter int DEPTH = wlh_pkg::QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  wlh_pkg::op_t push_op,
    input  logic         pop,
    output wlh_pkg::op_t head,
    output logic         full,
    output logic         empty
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    wlh_pkg::op_t        entry_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == CNT_BITS'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: src/wlh_back.sv
// ----------------------------------------------------------------------------
// wlh_back
// histogram store: clearing pass, read-modify-write with bypass, result register
// ----------------------------------------------------------------------------
module wlh_back
#(
    parameter int MAX_LENGTH = wlh_pkg::MAX_LENGTH_DEF,
    parameter int COUNT_BITS = wlh_pkg::COUNT_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  wlh_pkg::op_t                        head,
    input  logic                                empty,
    output logic                                pop,
    output logic                                clear_busy,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [wlh_pkg::INDEX_BITS-1:0]      out_length,
    output logic [wlh_pkg::OUT_COUNT_BITS-1:0]  out_count
);

    localparam int DEPTH    = MAX_LENGTH + 1;
    localparam int LEN_BITS = $clog2(DEPTH);

    logic                  clr_busy_reg;
    logic [LEN_BITS-1:0]   clr_addr_reg;
    logic                  s1_valid_reg;
    wlh_pkg::op_t          s1_op_reg;
    logic                  byp_valid_reg;
    logic [LEN_BITS-1:0]   byp_addr_reg;
    logic [COUNT_BITS-1:0] byp_data_reg;
    logic                  out_valid_reg;
    logic [wlh_pkg::INDEX_BITS-1:0]     out_length_reg;
    logic [wlh_pkg::OUT_COUNT_BITS-1:0] out_count_reg;

    logic [COUNT_BITS-1:0] rd_data;
    logic [COUNT_BITS-1:0] cur_count;
    logic [COUNT_BITS-1:0] inc_count;
    logic [LEN_BITS-1:0]   s1_addr;
    logic [31:0]           count_wide;
    logic                  out_load_ok;
    logic                  s1_done;
    logic                  s1_write;
    logic                  wr_en;
    logic [LEN_BITS-1:0]   wr_addr;
    logic [COUNT_BITS-1:0] wr_data;

    assign s1_addr     = s1_op_reg.addr[LEN_BITS-1:0];
    assign cur_count   = (byp_valid_reg && byp_addr_reg == s1_addr) ? byp_data_reg : rd_data;
    assign inc_count   = (&cur_count) ? cur_count : cur_count + 1'b1;
    assign count_wide  = 32'(cur_count);
    assign out_load_ok = !out_valid_reg || out_ready;
    assign s1_write    = s1_valid_reg && (s1_op_reg.kind == wlh_pkg::OP_INC);
    assign s1_done     = (s1_op_reg.kind == wlh_pkg::OP_INC) || out_load_ok;
    assign pop         = !clr_busy_reg && !empty && (!s1_valid_reg || s1_done);

    assign wr_en   = clr_busy_reg || s1_write;
    assign wr_addr = clr_busy_reg ? clr_addr_reg : s1_addr;
    assign wr_data = clr_busy_reg ? '0 : inc_count;

    wlh_ram
    #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    )
    u_ram
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (pop),
        .rd_addr (head.addr[LEN_BITS-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == LEN_BITS'(MAX_LENGTH))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (pop)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_valid_reg && s1_done)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_write)
            begin
                byp_valid_reg <= 1'b1;
            end
            if (s1_valid_reg && s1_op_reg.kind == wlh_pkg::OP_READ && out_load_ok)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_op_reg <= head;
        end
        if (s1_write)
        begin
            byp_addr_reg <= s1_addr;
            byp_data_reg <= inc_count;
        end
        if (s1_valid_reg && s1_op_reg.kind == wlh_pkg::OP_READ && out_load_ok)
        begin
            out_length_reg <= s1_op_reg.bin_length;
            out_count_reg  <= s1_op_reg.in_range ? count_wide[wlh_pkg::OUT_COUNT_BITS-1:0] : '0;
        end
    end

    assign clear_busy = clr_busy_reg;
    assign out_valid  = out_valid_reg;
    assign out_length = out_length_reg;
    assign out_count  = out_count_reg;

endmodule

// File: src/word_length_histogram_top.sv
// ----------------------------------------------------------------------------
// word_length_histogram_top
// word length histogram over a text byte stream
// ----------------------------------------------------------------------------
// Takes one transaction per clock cycle while the operation queue is not full
// and no clearing pass runs. A transaction is a text byte, an end of text or a
// bin read (tuser). Space, tab and newline end a word; the finished word
// increments the bin of its length (saturating at MAX_LENGTH) and counts
// saturate at 2^COUNT_BITS-1. Each bin update is a read-modify-write through
// the one-read, one-write histogram ram, read on pop and written from stage s1,
// with a one-entry write bypass so back-to-back updates of one bin run at full
// rate. A read passes through the queue, stage s1 and the result register;
// results keep transaction order. After reset the ram is cleared one bin per
// cycle, so s_axis_tready stays low until every bin is cleared. A stalled master
// side backs up through a four-entry operation queue before s_axis_tready drops.
module word_length_histogram_top
#(
    parameter int MAX_LENGTH = wlh_pkg::MAX_LENGTH_DEF,
    parameter int COUNT_BITS = wlh_pkg::COUNT_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // text_byte[7:0], bin_index[17:8], zero
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // bin_length[9:0], bin_count[25:10], zero
);

    logic                                 push;
    wlh_pkg::op_t                         push_op;
    wlh_pkg::op_t                         head;
    logic                                 pop;
    logic                                 full;
    logic                                 empty;
    logic                                 clear_busy;
    logic [wlh_pkg::INDEX_BITS-1:0]       out_length;
    logic [wlh_pkg::OUT_COUNT_BITS-1:0]   out_count;

    wlh_front
    #(
        .MAX_LENGTH (MAX_LENGTH)
    )
    u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .action     (s_axis_tuser),
        .text_byte  (s_axis_tdata[7:0]),
        .bin_index  (s_axis_tdata[17:8]),
        .queue_full (full),
        .clear_busy (clear_busy),
        .push       (push),
        .op         (push_op)
    );

    wlh_fifo
    #(
        .DEPTH (wlh_pkg::QUEUE_DEPTH)
    )
    u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head    (head),
        .full    (full),
        .empty   (empty)
    );

    wlh_back
    #(
        .MAX_LENGTH (MAX_LENGTH),
        .COUNT_BITS (COUNT_BITS)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .clear_busy (clear_busy),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_length (out_length),
        .out_count  (out_count)
    );

    assign m_axis_tdata = {6'b0, out_count, out_length};

endmodule

// File: src/wlh_checker.sv
// ----------------------------------------------------------------------------
// wlh_checker
// port-level checks of the word length histogram
// ----------------------------------------------------------------------------
module wlh_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // stalled result transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // clearing pass blocks input right after reset
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !s_axis_tready)
        else $error("input accepted during clearing pass");

    // no word has length zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[9:0] == 10'd0 |-> m_axis_tdata[25:10] == 16'd0)
        else $error("bin zero counted a word");

    // padding stays zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[31:26] == 6'd0)
        else $error("result padding not zero");

endmodule

bind word_length_histogram_top wlh_checker u_chk
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
